### hdl/tcg_pkg.sv
// ----------------------------------------------------------------------------
// tcg_pkg
// Shared types, codes and helper functions of the TCP checksum generator.
// ----------------------------------------------------------------------------
package tcg_pkg;

    // Widths of the stream payloads and of the raw pseudo-header sum
    localparam int TCG_IN_DATA_W  = 296;
    localparam int TCG_OUT_DATA_W = 24;
    localparam int TCG_RAW_W      = 21;

    // Default depth of the queue between front and back
    localparam int TCG_QUEUE_DEPTH = 4;

    // Request commands carried in tuser
    localparam logic [1:0] CMD_BEGIN_V4 = 2'd0;
    localparam logic [1:0] CMD_BEGIN_V6 = 2'd1;
    localparam logic [1:0] CMD_DATA     = 2'd2;

    // Length status codes
    localparam logic [1:0] ST_MATCH = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_EXTRA = 2'd2;

    localparam logic [7:0]  TCP_PROTO = 8'd6;
    localparam logic [15:0] MASK16    = 16'hFFFF;
    localparam logic [15:0] CSUM_WORD = 16'd8;

    // Kind of a queued request
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_DATA  = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [TCG_RAW_W-1:0] raw_sum;
        logic [15:0]          seg_bytes;
        logic [15:0]          word;
        logic                 last;
    } t_item;

    // Plain sum of the four 16-bit words of a 64-bit value
    function automatic logic [17:0] sum4(input logic [63:0] v);
        sum4 = 18'(v[15:0]) + 18'(v[31:16]) + 18'(v[47:32]) + 18'(v[63:48]);
    endfunction

    // Ones' complement add of a word to a folded sum
    function automatic logic [15:0] fold_add(input logic [15:0] acc, input logic [15:0] v);
        logic [16:0] s;
        s = {1'b0, acc} + {1'b0, v};
        fold_add = s[15:0] + 16'(s[16]);
    endfunction

    // Fold a wide plain sum down to 16 bits with end-around carry
    function automatic logic [15:0] fold_raw(input logic [TCG_RAW_W-1:0] raw);
        logic [16:0] t;
        t = {1'b0, raw[15:0]} + 17'(raw[TCG_RAW_W-1:16]);
        fold_raw = t[15:0] + 16'(t[16]);
    endfunction

endpackage

### hdl/tcg_front.sv
// ----------------------------------------------------------------------------
// tcg_front
// Accepts requests, drops unused commands and sums the pseudo header over
// two register stages before the request enters the queue.
// ----------------------------------------------------------------------------
module tcg_front
    import tcg_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [TCG_IN_DATA_W-1:0] i_data,
    input  logic [1:0]               i_cmd,
    input  logic                     i_last,
    input  logic                     i_q_full,
    output logic                     o_q_push,
    output t_item                    o_q_item
);

    typedef struct packed {
        logic        kind;
        logic [17:0] p_src_hi;
        logic [17:0] p_src_lo;
        logic [17:0] p_dst_hi;
        logic [17:0] p_dst_lo;
        logic [15:0] seg_bytes;
        logic [15:0] word;
        logic        last;
    } t_stage1;

    logic [63:0] w_src_hi, w_src_lo, w_dst_hi, w_dst_lo;
    logic [15:0] w_pkt_length;
    logic [3:0]  w_header_words;
    logic [15:0] w_data_word;
    logic        w_v6;

    logic    r_s1_v, r_s2_v;
    t_stage1 r_s1, n_s1;
    t_item   r_s2, n_s2;
    logic    w_ready1, w_ready2, w_keep;

    assign w_src_hi       = i_data[63:0];
    assign w_src_lo       = i_data[127:64];
    assign w_dst_hi       = i_data[191:128];
    assign w_dst_lo       = i_data[255:192];
    assign w_pkt_length   = i_data[271:256];
    assign w_header_words = i_data[275:272];
    assign w_data_word    = i_data[291:276];
    assign w_v6           = (i_cmd == CMD_BEGIN_V6);

    assign w_ready2 = !r_s2_v || !i_q_full;
    assign w_ready1 = !r_s1_v || w_ready2;
    assign o_ready  = w_ready1;
    assign o_q_push = r_s2_v && !i_q_full;
    assign o_q_item = r_s2;

    // drop the unused command code here
    always_comb begin
        unique case (i_cmd) inside
            CMD_BEGIN_V4, CMD_BEGIN_V6, CMD_DATA: w_keep = 1'b1;
            default:                              w_keep = 1'b0;
        endcase
    end

    always_comb begin
        n_s1.kind     = (i_cmd == CMD_DATA) ? KIND_DATA : KIND_BEGIN;
        n_s1.p_src_hi = w_v6 ? sum4(w_src_hi) : 18'd0;
        n_s1.p_dst_hi = w_v6 ? sum4(w_dst_hi) : 18'd0;
        n_s1.p_src_lo = w_v6 ? sum4(w_src_lo) : sum4({32'd0, w_src_lo[31:0]});
        n_s1.p_dst_lo = w_v6 ? sum4(w_dst_lo) : sum4({32'd0, w_dst_lo[31:0]});
        // IPv4 length wraps at 16 bits
        n_s1.seg_bytes = w_v6 ? w_pkt_length
                              : w_pkt_length - {10'd0, w_header_words, 2'b00};
        n_s1.word      = w_data_word;
        n_s1.last      = i_last;
    end

    always_comb begin
        n_s2.kind      = r_s1.kind;
        n_s2.raw_sum   = TCG_RAW_W'(r_s1.p_src_hi) + TCG_RAW_W'(r_s1.p_src_lo)
                       + TCG_RAW_W'(r_s1.p_dst_hi) + TCG_RAW_W'(r_s1.p_dst_lo)
                       + TCG_RAW_W'(TCP_PROTO) + TCG_RAW_W'(r_s1.seg_bytes);
        n_s2.seg_bytes = r_s1.seg_bytes;
        n_s2.word      = r_s1.word;
        n_s2.last      = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (w_ready2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_ready1) begin
                r_s1_v <= i_valid && w_keep;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready2) begin
            r_s2 <= n_s2;
        end
        if (w_ready1) begin
            r_s1 <= n_s1;
        end
    end

endmodule

### hdl/tcg_queue.sv
// ----------------------------------------------------------------------------
// tcg_queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module tcg_queue
    import tcg_pkg::*;
#(
    parameter int DEPTH = TCG_QUEUE_DEPTH
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_empty,
    output t_item o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

### hdl/tcg_back.sv
// ----------------------------------------------------------------------------
// tcg_back
// Keeps the running ones' complement sum and word count, and drives the
// result register on the final word.
// ----------------------------------------------------------------------------
module tcg_back
    import tcg_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_item                     i_item,
    output logic                      o_pop,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [TCG_OUT_DATA_W-1:0] o_m_tdata
);

    logic [15:0] r_sum, n_sum;
    logic [15:0] r_seg, n_seg;
    logic [15:0] r_idx, n_idx;
    logic        r_extra, n_extra;
    logic        r_ov, n_ov;
    logic [15:0] r_csum, n_csum;
    logic [1:0]  r_status, n_status;

    logic        w_out_free, w_take, w_load;
    logic [16:0] w_idx2, w_needed2;
    logic [15:0] w_needed, w_v;

    assign w_out_free = !r_ov || i_m_tready;
    assign w_take     = i_valid && ((i_item.kind == KIND_BEGIN) || !i_item.last || w_out_free);
    assign o_pop      = w_take;
    assign w_idx2     = {r_idx, 1'b0};
    assign w_needed2  = {1'b0, r_seg} + 17'd1;
    assign w_needed   = w_needed2[16:1];

    always_comb begin
        n_sum    = r_sum;
        n_seg    = r_seg;
        n_idx    = r_idx;
        n_extra  = r_extra;
        n_csum   = r_csum;
        n_status = r_status;
        w_load   = 1'b0;
        w_v      = i_item.word;
        if (w_take) begin
            if (i_item.kind == KIND_BEGIN) begin
                n_sum   = fold_raw(i_item.raw_sum);
                n_seg   = i_item.seg_bytes;
                n_idx   = '0;
                n_extra = 1'b0;
            end else begin
                if (w_idx2 < {1'b0, r_seg}) begin
                    // the checksum field counts as zero; odd tail keeps its high byte
                    if (r_idx == CSUM_WORD) begin
                        w_v = '0;
                    end else if (w_idx2 + 17'd1 == {1'b0, r_seg}) begin
                        w_v = i_item.word & 16'hFF00;
                    end
                    n_sum = fold_add(r_sum, w_v);
                end else begin
                    n_extra = 1'b1;
                end
                if (r_idx != MASK16) begin
                    n_idx = r_idx + 16'd1;
                end
                if (i_item.last) begin
                    w_load = 1'b1;
                    n_csum = ~n_sum;
                    if (n_idx < w_needed) begin
                        n_status = ST_SHORT;
                    end else if (n_extra) begin
                        n_status = ST_EXTRA;
                    end else begin
                        n_status = ST_MATCH;
                    end
                end
            end
        end
    end

    always_comb begin
        if (w_load) begin
            n_ov = 1'b1;
        end else if (i_m_tready) begin
            n_ov = 1'b0;
        end else begin
            n_ov = r_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_seg   <= '0;
            r_idx   <= '0;
            r_extra <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_sum   <= n_sum;
            r_seg   <= n_seg;
            r_idx   <= n_idx;
            r_extra <= n_extra;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_csum   <= n_csum;
        r_status <= n_status;
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {{(TCG_OUT_DATA_W - 18){1'b0}}, r_status, r_csum};

endmodule

### hdl/tcp_checksum_generator.sv
// ----------------------------------------------------------------------------
// tcp_checksum_generator
// TCP checksum over the IPv4 or IPv6 pseudo header and the segment words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Moves
//  i_s_*     in         begin IPv4 / begin IPv6 / segment word requests
//  o_m_*     out        checksum and length status, one per final word
//
//  One request per cycle sustained while the output takes results; the final
//  word passes the two front stages, the queue and the back's result register.
//  Two front stages sum the pseudo header; the back does one 16-bit add with
//  end-around carry per cycle, which sets the rate.
//  A stalled output holds its result while the queue keeps taking requests.
//  Synchronous active-low reset clears the sum, length and word count.
// ----------------------------------------------------------------------------
module tcp_checksum_generator
    import tcg_pkg::*;
#(
    parameter int QUEUE_DEPTH = TCG_QUEUE_DEPTH
)
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // src_hi[63:0], src_lo[127:64], dst_hi[191:128], dst_lo[255:192],
    // pkt_length[271:256], header_words[275:272], data_word[291:276], zero pad
    input  logic [TCG_IN_DATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [1:0]                i_s_tuser,
    input  logic                      i_s_tlast,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // checksum[15:0], length_status[17:16], zero pad
    output logic [TCG_OUT_DATA_W-1:0] o_m_tdata
);

    logic  w_q_full, w_q_empty, w_q_push, w_q_pop;
    t_item w_q_in, w_q_head;

    tcg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_data   (i_s_tdata),
        .i_cmd    (i_s_tuser),
        .i_last   (i_s_tlast),
        .i_q_full (w_q_full),
        .o_q_push (w_q_push),
        .o_q_item (w_q_in)
    );

    tcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_item  (w_q_in),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    tcg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!w_q_empty),
        .i_item     (w_q_head),
        .o_pop      (w_q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

### hdl/tcg_checker.sv
// ----------------------------------------------------------------------------
// tcg_checker
// Port-level checks on the result channel of the checksum generator.
// ----------------------------------------------------------------------------
module tcg_checker
    import tcg_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_m_tvalid,
    input logic                      i_m_tready,
    input logic [TCG_OUT_DATA_W-1:0] o_m_tdata
);

    logic [1:0] w_status;
    assign w_status = o_m_tdata[17:16];

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (w_status == ST_MATCH) || (w_status == ST_SHORT)
                    || (w_status == ST_EXTRA))
        else $error("undefined length status");

    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[TCG_OUT_DATA_W-1:18] == '0)
        else $error("result padding not zero");

endmodule

bind tcp_checksum_generator tcg_checker u_tcg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

### tb/tcp_checksum_generator_tb.sv
// ----------------------------------------------------------------------------
// tcp_checksum_generator_tb
// Self-checking bench for the TCP checksum generator. Begin requests and
// segment words are driven on the input stream while a predictor, run on
// each accepted request, folds the pseudo header and the words into a ones'
// complement sum and queues each checksum and length status, which are
// compared with the output stream in order. Directed cases come first, then
// random segments with noise under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tcp_checksum_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tcg_pkg::*;

    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 20;
    localparam int         PHASE_ITEMS  = 140;
    localparam int         HOLD_CYCLES  = 400;

    typedef struct {
        logic [1:0]  cmd;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] pkt_len;
        logic [3:0]  hdr_words;
        logic [15:0] word;
        logic        last;
    } t_tcp_req;

    typedef struct {
        logic [15:0] csum;
        logic [1:0]  status;
    } t_csum_res;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [TCG_IN_DATA_W-1:0]  s_tdata   = '0;
    logic [1:0]                s_tuser   = CMD_DATA;
    logic                      s_tlast   = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [TCG_OUT_DATA_W-1:0] m_tdata;

    // Predictor state
    logic [15:0] pred_sum       = '0;
    logic [15:0] pred_seg_bytes = '0;
    logic [15:0] pred_word_idx  = '0;
    logic        pred_extra     = 1'b0;

    t_csum_res csum_expected_q[$];
    int        mismatch_cnt   = 0;
    int        items_sent     = 0;
    int        sender_idle_pct = 0;
    int        recv_stall_pct  = 0;
    int        hold_len        = 0;
    int        cycle_cnt       = 0;

    tcp_checksum_generator DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: a hold-off request overrides the random stall
    initial begin
        forever begin
            @(negedge clk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                hold_len--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic logic [15:0] oc_add64(input logic [15:0] acc, input logic [63:0] v);
        for (int k = 0; k < 4; k++)
            acc = oc_add(acc, v[16*k +: 16]);
        return acc;
    endfunction

    task automatic csum_predict(input t_tcp_req r);
        logic [15:0] s;
        logic [15:0] v;
        logic [16:0] needed;
        t_csum_res   res;
        case (r.cmd) inside
            CMD_BEGIN_V4, CMD_BEGIN_V6: begin
                s = '0;
                if (r.cmd == CMD_BEGIN_V4) begin
                    // wraps when the header claims more than the total length
                    pred_seg_bytes = r.pkt_len - {10'd0, r.hdr_words, 2'd0};
                    s = oc_add64(s, {32'd0, r.src_lo[31:0]});
                    s = oc_add64(s, {32'd0, r.dst_lo[31:0]});
                end else begin
                    pred_seg_bytes = r.pkt_len;
                    s = oc_add64(s, r.src_hi);
                    s = oc_add64(s, r.src_lo);
                    s = oc_add64(s, r.dst_hi);
                    s = oc_add64(s, r.dst_lo);
                end
                s = oc_add(s, {8'd0, TCP_PROTO});
                s = oc_add(s, pred_seg_bytes);
                pred_sum      = s;
                pred_word_idx = '0;
                pred_extra    = 1'b0;
            end
            CMD_DATA: begin
                if ({pred_word_idx, 1'b0} < {1'b0, pred_seg_bytes}) begin
                    v = r.word;
                    if (pred_word_idx == CSUM_WORD)
                        v = '0;
                    else if ({pred_word_idx, 1'b0} + 17'd1 == {1'b0, pred_seg_bytes})
                        v = {r.word[15:8], 8'd0};
                    pred_sum = oc_add(pred_sum, v);
                end else begin
                    pred_extra = 1'b1;
                end
                if (pred_word_idx != MASK16)
                    pred_word_idx++;
                if (r.last) begin
                    needed   = ({1'b0, pred_seg_bytes} + 17'd1) >> 1;
                    res.csum = ~pred_sum;
                    if ({1'b0, pred_word_idx} < needed)
                        res.status = ST_SHORT;
                    else if (pred_extra)
                        res.status = ST_EXTRA;
                    else
                        res.status = ST_MATCH;
                    csum_expected_q.push_back(res);
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [TCG_IN_DATA_W-1:0] pack_req(input t_tcp_req r);
        logic [TCG_IN_DATA_W-1:0] d;
        d = '0;
        d[63:0]    = r.src_hi;
        d[127:64]  = r.src_lo;
        d[191:128] = r.dst_hi;
        d[255:192] = r.dst_lo;
        d[271:256] = r.pkt_len;
        d[275:272] = r.hdr_words;
        d[291:276] = r.word;
        return d;
    endfunction

    function automatic t_tcp_req rand_req();
        t_tcp_req r;
        r.cmd       = 2'($urandom_range(3));
        r.src_hi    = {$urandom, $urandom};
        r.src_lo    = {$urandom, $urandom};
        r.dst_hi    = {$urandom, $urandom};
        r.dst_lo    = {$urandom, $urandom};
        r.pkt_len   = 16'($urandom);
        r.hdr_words = 4'($urandom);
        r.word      = 16'($urandom);
        r.last      = 1'($urandom);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk) begin : result_check
        t_csum_res want;
        if (rst_n && m_tvalid && m_tready) begin
            if (csum_expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result checksum %h status %0d",
                                          m_tdata[15:0], m_tdata[17:16]));
            end else begin
                want = csum_expected_q.pop_front();
                if (m_tdata[15:0] != want.csum)
                    report_mismatch($sformatf("checksum: expected %h, got %h",
                                              want.csum, m_tdata[15:0]));
                if (m_tdata[17:16] != want.status)
                    report_mismatch($sformatf("length status: expected %0d, got %0d",
                                              want.status, m_tdata[17:16]));
            end
        end
    end

    // Called and returns at a falling edge; valid stays high between back-to-back requests
    task automatic send_req(input t_tcp_req r);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tlast  <= r.last;
        s_tdata  <= pack_req(r);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        csum_predict(r);
        if (r.cmd != CMD_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        wait (csum_expected_q.size() == 0);
        @(negedge clk);
    endtask

    task automatic send_word(input logic [15:0] w, input logic last);
        t_tcp_req r;
        r      = rand_req();
        r.cmd  = CMD_DATA;
        r.word = w;
        r.last = last;
        send_req(r);
    endtask

    task automatic send_begin(input logic [1:0] cmd, input logic [63:0] addr,
                              input logic [15:0] len, input logic [3:0] hw);
        t_tcp_req r;
        r           = rand_req();
        r.cmd       = cmd;
        r.src_hi    = addr;
        r.src_lo    = addr;
        r.dst_hi    = addr;
        r.dst_lo    = addr;
        r.pkt_len   = len;
        r.hdr_words = hw;
        send_req(r);
    endtask

    task automatic test_data_before_begin();
        send_word(16'h0000, 1'b0);
        send_word(MASK16, 1'b1);
    endtask

    task automatic test_unused_cmd();
        t_tcp_req r;
        r.cmd       = CMD_UNUSED;
        r.src_hi    = '1;
        r.src_lo    = '1;
        r.dst_hi    = '1;
        r.dst_lo    = '1;
        r.pkt_len   = MASK16;
        r.hdr_words = '1;
        r.word      = MASK16;
        r.last      = 1'b1;
        send_req(r);
        // state must be untouched: still an extra word on the reset state
        send_word(16'h5A5A, 1'b1);
    endtask

    task automatic test_ipv4_lengths();
        send_begin(CMD_BEGIN_V4, '1, MASK16, 4'd15);
        send_word(MASK16, 1'b1);
        // header longer than the total length: the segment length wraps
        send_begin(CMD_BEGIN_V4, '0, 16'd20, 4'd15);
        send_word(16'h0000, 1'b1);
        // empty segment
        send_begin(CMD_BEGIN_V4, 64'h0123_4567_89AB_CDEF, 16'd0, 4'd0);
        send_word(16'h8001, 1'b1);
    endtask

    task automatic test_ipv6_odd_segment();
        // odd length past the checksum word: word eight is zeroed, the odd byte masked
        send_begin(CMD_BEGIN_V6, '1, 16'd19, 4'd0);
        for (int i = 0; i < 10; i++)
            send_word(MASK16, i == 9);
        // continue the same segment after its last word
        send_word(16'h1234, 1'b1);
    endtask

    task automatic run_segment();
        t_tcp_req    r;
        int          seg;
        int          needed;
        int          nwords;
        logic [15:0] seg_bytes;
        r   = rand_req();
        r.cmd = $urandom_range(1) ? CMD_BEGIN_V6 : CMD_BEGIN_V4;
        seg = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(40);
        if (r.cmd == CMD_BEGIN_V4) begin
            if ($urandom_range(7) != 0)
                r.pkt_len = 16'(seg + 4 * r.hdr_words);
            seg_bytes = r.pkt_len - {10'd0, r.hdr_words, 2'd0};
        end else begin
            if ($urandom_range(15) != 0)
                r.pkt_len = 16'(seg);
            seg_bytes = r.pkt_len;
        end
        needed = (int'(seg_bytes) + 1) / 2;
        case ($urandom_range(9))
            0:       nwords = needed + $urandom_range(1, 3);
            1:       nwords = $urandom_range(needed);
            default: nwords = needed;
        endcase
        // cap the stray huge lengths, which then end short
        if (nwords > 160)
            nwords = $urandom_range(1, 24);
        if (nwords < 1)
            nwords = 1;
        send_req(r);
        for (int i = 0; i < nwords; i++)
            send_word(16'($urandom), i == nwords - 1);
    endtask

    task automatic send_noise();
        t_tcp_req r;
        repeat ($urandom_range(1, 3)) begin
            r     = rand_req();
            r.cmd = $urandom_range(1) ? CMD_UNUSED : CMD_DATA;
            send_req(r);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int start;
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0)
                send_noise();
            else
                run_segment();
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_len        = HOLD_CYCLES;
        repeat (16)
            run_segment();
        wait_drain();
    endtask

    task automatic test_random();
        run_phase(0, 0);
        run_phase(69, 0);
        run_phase(0, 69);
        run_phase(18, 18);
    endtask

    initial begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_data_before_begin();
        test_unused_cmd();
        test_ipv4_lengths();
        test_ipv6_odd_segment();
        wait_drain();
        test_backpressure();
        test_random();

        s_tvalid <= 1'b0;
        wait (csum_expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0 && csum_expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
